>>> rtl/adjacency_matrix_dfs_components_unit_macros.svh
// Assertion helpers for the adjacency matrix walk unit
`ifndef ADJACENCY_MATRIX_DFS_COMPONENTS_UNIT_MACROS_SVH
`define ADJACENCY_MATRIX_DFS_COMPONENTS_UNIT_MACROS_SVH

// same-cycle implication
`define AMDFS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AMDFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/amdfs_pkg.sv
`default_nettype none

package amdfs_pkg;

   localparam int DEF_MAX_VERTICES = 32;
   localparam int DEF_STACK_DEPTH  = 1024;
   localparam int VERTEX_CAP       = 32;
   localparam int COUNT_W          = 6;
   localparam int VERTEX_W         = 5;
   localparam int COMP_W           = 5;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd5;

   typedef enum logic [1:0] {
      CMD_ADD_EDGE    = 2'd0,
      CMD_REMOVE_EDGE = 2'd1,
      CMD_WALK        = 2'd2,
      CMD_COMPONENTS  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_INVALID_EDGE  = 2'd1,
      ST_EDGE_MISSING  = 2'd2,
      ST_INVALID_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [COUNT_W-1:0] from_vertex;
      logic [COUNT_W-1:0] to_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [VERTEX_W-1:0] vertex;
      logic [COMP_W-1:0]   component;
      logic                last;
   } rsp_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEED   = 6'b000010,
      S_POP    = 6'b000100,
      S_CHECK  = 6'b001000,
      S_PUSH   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic edge_go;
      logic walk_go;
      logic seed_skip;
      logic seed_push;
      logic pop;
      logic walk_end;
      logic visit;
      logic push;
      logic finish;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic req_walk;
      logic seed_done;
      logic seed_visited;
      logic stack_empty;
      logic cur_visited;
      logic pend_empty;
      logic comp_mode;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/amdfs_ctrl.sv
`default_nettype none

module amdfs_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire amdfs_pkg::sts_type sts,
   output amdfs_pkg::ctl_type     ctl
);

   amdfs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amdfs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         amdfs_pkg::S_IDLE: begin
            if (start) begin
               if (sts.req_walk) begin
                  ctl.walk_go = 1'b1;
                  state_in    = amdfs_pkg::S_SEED;
               end else begin
                  ctl.edge_go = 1'b1;
               end
            end
         end
         amdfs_pkg::S_SEED: begin
            if (sts.seed_done) begin
               state_in = amdfs_pkg::S_FINISH;
            end else if (sts.seed_visited) begin
               ctl.seed_skip = 1'b1;
            end else begin
               ctl.seed_push = 1'b1;
               state_in      = amdfs_pkg::S_POP;
            end
         end
         amdfs_pkg::S_POP: begin
            if (sts.stack_empty) begin
               ctl.walk_end = 1'b1;
               state_in     = sts.comp_mode ? amdfs_pkg::S_SEED : amdfs_pkg::S_FINISH;
            end else begin
               ctl.pop  = 1'b1;
               state_in = amdfs_pkg::S_CHECK;
            end
         end
         amdfs_pkg::S_CHECK: begin
            if (sts.cur_visited) begin
               state_in = amdfs_pkg::S_POP;
            end else begin
               ctl.visit = 1'b1;
               state_in  = amdfs_pkg::S_PUSH;
            end
         end
         amdfs_pkg::S_PUSH: begin
            if (sts.pend_empty) begin
               state_in = amdfs_pkg::S_POP;
            end else begin
               ctl.push = 1'b1;
            end
         end
         amdfs_pkg::S_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = amdfs_pkg::S_IDLE;
         end
         default: begin
            state_in = amdfs_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != amdfs_pkg::S_IDLE);

endmodule

`default_nettype wire

>>> rtl/amdfs_datapath.sv
`default_nettype none

module amdfs_datapath #(
   parameter int MAX_VERTICES = amdfs_pkg::DEF_MAX_VERTICES,
   parameter int STACK_DEPTH  = amdfs_pkg::DEF_STACK_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire amdfs_pkg::req_type            req_data,
   input  wire logic                          csr_we,
   input  wire logic [amdfs_pkg::COUNT_W-1:0] csr_wdata,
   input  wire amdfs_pkg::ctl_type            ctl,
   output amdfs_pkg::sts_type                 sts,
   output logic                               rsp_valid,
   output amdfs_pkg::rsp_type                 rsp_data
);

   localparam int VCAP = (MAX_VERTICES < amdfs_pkg::VERTEX_CAP) ?
                         MAX_VERTICES : amdfs_pkg::VERTEX_CAP;
   localparam int VW   = $clog2(VCAP);
   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int SPW  = $clog2(STACK_DEPTH + 1);
   localparam int CW   = amdfs_pkg::COUNT_W;

   logic [CW-1:0]   count_ff;
   logic [VCAP-1:0] adj_ff [VCAP];
   logic [VCAP-1:0] visited_ff;
   logic [VCAP-1:0] pend_ff, pend_in;
   logic [SPW-1:0]  sp_ff;
   logic [CW-1:0]   seed_ff;
   logic [amdfs_pkg::COMP_W-1:0] comp_ff;
   logic            comp_mode_ff;
   logic [VW-1:0]   rd_ff;
   logic [VW-1:0]   hold_vertex_ff;
   logic [amdfs_pkg::COMP_W-1:0] hold_comp_ff;
   logic            hold_valid_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   amdfs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [VW-1:0]   stack_mem [STACK_DEPTH];

   logic [CW-1:0]   n;
   logic [VCAP-1:0] nmask;
   logic [VCAP-1:0] rd_onehot;
   logic [VW-1:0]   low_idx;
   logic [SPW-1:0]  sp_dec;
   logic            stack_full;
   logic [VW-1:0]   fi, ti;
   logic            f_ok, t_ok, edge_bit;
   logic [1:0]      edge_status;
   logic            stack_we;
   logic [AW-1:0]   stack_waddr;
   logic [VW-1:0]   stack_wdata;

   // effective vertex count, saturated into 1..VCAP
   always_comb begin
      if (count_ff == '0) begin
         n = CW'(1);
      end else if (count_ff > CW'(VCAP)) begin
         n = CW'(VCAP);
      end else begin
         n = count_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < VCAP; i++) begin
         nmask[i] = (CW'(i) < n);
      end
   end

   always_comb begin
      low_idx = '0;
      for (int i = VCAP - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            low_idx = VW'(i);
         end
      end
   end

   assign rd_onehot  = VCAP'(1) << rd_ff;
   assign sp_dec     = sp_ff - SPW'(1);
   assign stack_full = (sp_ff == SPW'(STACK_DEPTH));

   assign fi       = req_data.from_vertex[VW-1:0];
   assign ti       = req_data.to_vertex[VW-1:0];
   assign f_ok     = (req_data.from_vertex < n);
   assign t_ok     = (req_data.to_vertex < n);
   assign edge_bit = adj_ff[fi][ti];

   always_comb begin
      if (req_data.command == amdfs_pkg::CMD_ADD_EDGE) begin
         edge_status = (f_ok && t_ok && (fi != ti)) ? amdfs_pkg::ST_OK
                                                    : amdfs_pkg::ST_INVALID_EDGE;
      end else if (!(f_ok && t_ok)) begin
         edge_status = amdfs_pkg::ST_INVALID_INDEX;
      end else begin
         edge_status = edge_bit ? amdfs_pkg::ST_OK : amdfs_pkg::ST_EDGE_MISSING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= amdfs_pkg::COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VCAP; i++) begin
            adj_ff[i] <= '0;
         end
      end else if (ctl.edge_go && (edge_status == amdfs_pkg::ST_OK)) begin
         adj_ff[fi][ti] <= (req_data.command == amdfs_pkg::CMD_ADD_EDGE);
      end
   end

   // stack memory, registered read
   always_comb begin
      stack_we    = ctl.seed_push || (ctl.push && !stack_full);
      stack_waddr = ctl.seed_push ? '0 : sp_ff[AW-1:0];
      stack_wdata = ctl.seed_push ? seed_ff[VW-1:0] : low_idx;
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      rd_ff <= stack_mem[sp_dec[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         visited_ff   <= '0;
         comp_ff      <= '0;
         seed_ff      <= '0;
         comp_mode_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (ctl.walk_go) begin
            sp_ff         <= '0;
            visited_ff    <= '0;
            comp_ff       <= '0;
            seed_ff       <= '0;
            comp_mode_ff  <= (req_data.command == amdfs_pkg::CMD_COMPONENTS);
            hold_valid_ff <= 1'b0;
         end
         if (ctl.seed_skip) begin
            seed_ff <= seed_ff + CW'(1);
         end
         if (ctl.seed_push) begin
            sp_ff <= SPW'(1);
         end
         if (ctl.walk_end) begin
            seed_ff <= seed_ff + CW'(1);
            comp_ff <= comp_ff + 1'b1;
         end
         if (ctl.pop) begin
            sp_ff <= sp_dec;
         end
         if (ctl.push && !stack_full) begin
            sp_ff <= sp_ff + SPW'(1);
         end
         if (ctl.visit) begin
            visited_ff    <= visited_ff | rd_onehot;
            hold_valid_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (ctl.visit) begin
         pend_in = adj_ff[rd_ff] & ~(visited_ff | rd_onehot) & nmask;
      end else if (ctl.push) begin
         pend_in = pend_ff & (pend_ff - VCAP'(1));
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (ctl.visit) begin
         hold_vertex_ff <= rd_ff;
         hold_comp_ff   <= comp_ff;
      end
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (ctl.edge_go) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = edge_status;
         rsp_data_in.vertex    = '0;
         rsp_data_in.component = '0;
         rsp_data_in.last      = 1'b1;
      end else if ((ctl.visit && hold_valid_ff) || ctl.finish) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = amdfs_pkg::ST_OK;
         rsp_data_in.vertex    = amdfs_pkg::VERTEX_W'(hold_vertex_ff);
         rsp_data_in.component = hold_comp_ff;
         rsp_data_in.last      = ctl.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      sts.req_walk     = (req_data.command == amdfs_pkg::CMD_WALK) ||
                         (req_data.command == amdfs_pkg::CMD_COMPONENTS);
      sts.seed_done    = (seed_ff == n);
      sts.seed_visited = visited_ff[seed_ff[VW-1:0]];
      sts.stack_empty  = (sp_ff == '0);
      sts.cur_visited  = visited_ff[rd_ff];
      sts.pend_empty   = (pend_ff == '0);
      sts.comp_mode    = comp_mode_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/adjacency_matrix_dfs_components_unit.sv
`default_nettype none
// Directed graph in an adjacency bit matrix with depth-first walks.
// Command beats: req_data is taken at a clock edge with start high and busy low.
// Results: beats on rsp_data, each marked by rsp_valid; last is set on
//   the final beat of each command. The receiver cannot stall; every beat is
//   shown for exactly one cycle.
// csr_we/csr_wdata write the vertex count; write only while busy is low.
// Add/remove edge: one status beat the cycle after acceptance; busy stays low,
//   so edge commands may be issued every cycle.
// Walk and components: busy rises after acceptance and falls in the cycle that
//   carries the last beat. While busy, the controller examines each seed (the
//   end of seeds check included), pops the stack through a registered read
//   into a check state, pushes the unvisited neighbours of each newly visited
//   vertex, checks for an empty stack at the end of each walk and passes
//   through a finish state. Vertices are emitted one beat behind their visit
//   so the last flag is known.
// Reset clears the matrix, visited bits and stack pointer, and sets the vertex
//   count to five; no clearing pass is needed.
`include "adjacency_matrix_dfs_components_unit_macros.svh"

module adjacency_matrix_dfs_components_unit #(
   parameter int MAX_VERTICES = amdfs_pkg::DEF_MAX_VERTICES,
   parameter int STACK_DEPTH  = amdfs_pkg::DEF_STACK_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire amdfs_pkg::req_type            req_data,
   output logic                               rsp_valid,
   output amdfs_pkg::rsp_type                 rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [amdfs_pkg::COUNT_W-1:0] csr_wdata
);

   amdfs_pkg::ctl_type ctl;
   amdfs_pkg::sts_type sts;

   amdfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   amdfs_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .STACK_DEPTH  (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `AMDFS_ASSERT_NEXT(a_walk_busy, clock, reset, start && !busy && sts.req_walk, busy, "walk not started")
   `AMDFS_ASSERT_NEXT(a_edge_beat, clock, reset, start && !busy && !sts.req_walk, rsp_valid && rsp_data.last, "edge status beat missing")
   `AMDFS_ASSERT_SAME(a_done_beat, clock, reset, $fell(busy), rsp_valid && rsp_data.last, "walk ended without last beat")
   `AMDFS_ASSERT_SAME(a_err_last, clock, reset, rsp_valid && (rsp_data.status != amdfs_pkg::ST_OK), rsp_data.last, "error status on non-final beat")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
   import amdfs_pkg::*;

   localparam int STALL_LIMIT = 40000;
   localparam int TAIL_CYCLES = 24;
   localparam int PHASE_ITEMS = 31;

   class walk_scoreboard;
      logic [31:0]        edge_rows [VERTEX_CAP];
      logic [31:0]        visited_mask;
      logic [COUNT_W-1:0] count_reg;
      rsp_type            batch [$];
      rsp_type            expected_beats [$];
      int                 errors;

      function new();
         foreach (edge_rows[i]) edge_rows[i] = '0;
         visited_mask = '0;
         count_reg = COUNT_RESET;
         errors = 0;
      endfunction

      function void set_count(logic [COUNT_W-1:0] value);
         count_reg = value;
      endfunction

      function int live_count();
         int n;
         n = int'(count_reg);
         if (n < 1) n = 1;
         if (n > VERTEX_CAP) n = VERTEX_CAP;
         return n;
      endfunction

      function void walk_from(int seed, int n, logic [COMP_W-1:0] comp);
         int      stk [DEF_STACK_DEPTH];
         int      sp;
         int      v;
         rsp_type b;
         stk[0] = seed;
         sp = 1;
         while (sp > 0) begin
            sp--;
            v = stk[sp];
            if (v < n && !visited_mask[v]) begin
               visited_mask[v] = 1'b1;
               b.status = ST_OK;
               b.vertex = v[VERTEX_W-1:0];
               b.component = comp;
               b.last = 1'b0;
               batch = {batch, b};
               for (int i = 0; i < n; i++) begin
                  if (edge_rows[v][i] && !visited_mask[i] && sp < DEF_STACK_DEPTH) begin
                     stk[sp] = i;
                     sp++;
                  end
               end
            end
         end
      endfunction

      function void note_command(req_type r);
         int                n;
         int                f;
         int                t;
         rsp_type           b;
         logic [COMP_W-1:0] comp;
         n = live_count();
         f = int'(r.from_vertex);
         t = int'(r.to_vertex);
         b = '0;
         batch.delete();
         case (r.command)
            CMD_ADD_EDGE: begin
               if (f < n && t < n && f != t) begin
                  edge_rows[f][t] = 1'b1;
                  b.status = ST_OK;
               end else begin
                  b.status = ST_INVALID_EDGE;
               end
               batch = {batch, b};
            end
            CMD_REMOVE_EDGE: begin
               if (f < n && t < n) begin
                  if (edge_rows[f][t]) begin
                     edge_rows[f][t] = 1'b0;
                     b.status = ST_OK;
                  end else begin
                     b.status = ST_EDGE_MISSING;
                  end
               end else begin
                  b.status = ST_INVALID_INDEX;
               end
               batch = {batch, b};
            end
            CMD_WALK: begin
               visited_mask = '0;
               walk_from(0, n, '0);
            end
            default: begin
               visited_mask = '0;
               comp = '0;
               for (int s = 0; s < n; s++) begin
                  if (!visited_mask[s]) begin
                     walk_from(s, n, comp);
                     comp = comp + 1'b1;
                  end
               end
            end
         endcase
         batch[batch.size() - 1].last = 1'b1;
         expected_beats = {expected_beats, batch};
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_beat(rsp_type got);
         rsp_type want;
         if (expected_beats.size() == 0) begin
            report($sformatf("beat with nothing pending: st %0d v %0d c %0d last %0d",
                             got.status, got.vertex, got.component, got.last));
            return;
         end
         want = expected_beats.pop_front();
         if (got.status !== want.status || got.vertex !== want.vertex ||
             got.component !== want.component || got.last !== want.last)
            report($sformatf("st %0d/%0d v %0d/%0d c %0d/%0d last %0d/%0d (got/exp)",
                             got.status, want.status, got.vertex, want.vertex,
                             got.component, want.component, got.last, want.last));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic [COUNT_W-1:0] csr_wdata = '0;

   walk_scoreboard board;
   int             idle_pct = 0;
   int             stall_cycles = 0;
   int             phase_counts [6] = '{9, 3, 16, 45, 6, 32};

   adjacency_matrix_dfs_components_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_command(req_data);
         if (rsp_valid) board.check_beat(rsp_data);
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_beat(req_type r);
      while ($urandom_range(0, 99) < idle_pct) pause(1);
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic issue(cmd_type c, int f, int t);
      req_type r;
      r.command = c;
      r.from_vertex = f[COUNT_W-1:0];
      r.to_vertex = t[COUNT_W-1:0];
      send_beat(r);
   endtask

   task automatic drain();
      pause(1);
      while (board.expected_beats.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      drain();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_count(value);
   endtask

   function automatic req_type random_beat(int n);
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.from_vertex = COUNT_W'($urandom_range(0, n - 1));
      r.to_vertex = COUNT_W'($urandom_range(0, n - 1));
      if (pick < 45) begin
         r.command = CMD_ADD_EDGE;
      end else if (pick < 62) begin
         r.command = CMD_REMOVE_EDGE;
      end else begin
         r.from_vertex = COUNT_W'($urandom_range(0, 63));
         r.to_vertex = COUNT_W'($urandom_range(0, 63));
         if (pick < 72) r.command = $urandom_range(0, 1) ? CMD_ADD_EDGE : CMD_REMOVE_EDGE;
         else if (pick < 86) r.command = CMD_WALK;
         else r.command = CMD_COMPONENTS;
      end
      return r;
   endfunction

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 30;

      // default count of five
      issue(CMD_ADD_EDGE, 0, 1);
      issue(CMD_ADD_EDGE, 0, 1);
      issue(CMD_ADD_EDGE, 2, 2);
      issue(CMD_ADD_EDGE, 5, 1);
      issue(CMD_ADD_EDGE, 1, 63);
      issue(CMD_ADD_EDGE, 1, 3);
      issue(CMD_ADD_EDGE, 3, 0);
      issue(CMD_ADD_EDGE, 4, 2);
      issue(CMD_REMOVE_EDGE, 4, 2);
      issue(CMD_REMOVE_EDGE, 4, 2);
      issue(CMD_REMOVE_EDGE, 63, 0);
      issue(CMD_WALK, 63, 63);
      issue(CMD_COMPONENTS, 42, 21);
      issue(CMD_ADD_EDGE, 0, 4);

      // oversize count saturates
      write_count(6'd63);
      issue(CMD_ADD_EDGE, 31, 30);
      issue(CMD_ADD_EDGE, 30, 31);
      issue(CMD_ADD_EDGE, 0, 31);
      issue(CMD_WALK, 0, 0);
      issue(CMD_COMPONENTS, 0, 0);

      // zero count acts as one
      write_count(6'd0);
      issue(CMD_ADD_EDGE, 0, 1);
      issue(CMD_WALK, 21, 42);
      issue(CMD_COMPONENTS, 0, 0);

      // high bits kept while hidden, back in use after growth
      write_count(6'd3);
      issue(CMD_COMPONENTS, 0, 0);
      write_count(6'd32);
      issue(CMD_COMPONENTS, 0, 0);

      for (int p = 0; p < 6; p++) begin
         if (p < 2) idle_pct = 30;
         else if (p < 4) idle_pct = 61;
         else idle_pct = 0;
         write_count(phase_counts[p][COUNT_W-1:0]);
         repeat (PHASE_ITEMS) send_beat(random_beat(board.live_count()));
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.expected_beats.size() != 0)
         board.report($sformatf("%0d beats never arrived", board.expected_beats.size()));
      if (board.errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
